// File: rtl/sfpc_pkg.sv
// shared types and constants for the squarefree prime factor counter
package sfpc_pkg;

  localparam int WIDTH_DEF = 16;
  localparam int COUNT_W   = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_START2,
    S_DIV2,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic take_quot;
    logic clr_ok;
    logic cnt_inc;
    logic next_div;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic loop_go;
    logic div_done;
    logic rem_zero;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/sfpc_in_if.sv
// number channel interface
interface sfpc_in_if #(
  parameter int WIDTH = sfpc_pkg::WIDTH_DEF
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// File: rtl/sfpc_out_if.sv
// result channel interface
interface sfpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfpc_pkg::COUNT_W-1:0]  prime_count;
  logic                          squarefree;

  modport source (output valid, output prime_count, output squarefree, input ready);
  modport sink   (input valid, input prime_count, input squarefree, output ready);
endinterface

// File: rtl/sfpc_div.sv
// iterative restoring divider, one quotient bit per cycle
module sfpc_div #(
  parameter int WIDTH = sfpc_pkg::WIDTH_DEF,
  parameter int DW    = sfpc_pkg::WIDTH_DEF / 2 + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [WIDTH-1:0] quotient,
  output logic             rem_zero,
  output logic             done,
  output logic             busy
);
  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] quo;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CW-1:0]    step;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;

  assign shifted  = {rem, quo[WIDTH-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = ~diff[DW];
  assign quotient = quo;
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[WIDTH-2:0], ge};
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/sfpc_dp.sv
// datapath: remaining value, trial divisor, its square, factor count, result register
module sfpc_dp #(
  parameter int WIDTH = sfpc_pkg::WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [WIDTH-1:0]             number,
  input  sfpc_pkg::cmd_t               cmd,
  output sfpc_pkg::status_t            sts,
  output logic [sfpc_pkg::COUNT_W-1:0] prime_count,
  output logic                         squarefree,
  output logic                         out_valid,
  input  logic                         out_ready
);
  localparam int DW  = WIDTH / 2 + 2;
  localparam int SQW = WIDTH + 2;

  logic [WIDTH-1:0]             rest;
  logic [DW-1:0]                div;
  logic [SQW-1:0]               sq;
  logic [sfpc_pkg::COUNT_W-1:0] count;
  logic                         ok;
  logic [sfpc_pkg::COUNT_W-1:0] fin_count;
  logic [WIDTH-1:0]             quo;
  logic                         rem_zero;
  logic                         div_done;
  logic                         div_busy;

  sfpc_div #(
    .WIDTH (WIDTH),
    .DW    (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rest),
    .divisor  (div),
    .quotient (quo),
    .rem_zero (rem_zero),
    .done     (div_done),
    .busy     (div_busy)
  );

  always_comb begin
    if (!ok) begin
      fin_count = '0;
    end else if (rest > WIDTH'(1) && count != sfpc_pkg::COUNT_MAX) begin
      fin_count = count + 1'b1;
    end else begin
      fin_count = count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest  <= number;
      div   <= DW'(2);
      sq    <= SQW'(4);
      count <= '0;
      ok    <= (number > WIDTH'(1));
    end else begin
      if (cmd.take_quot) begin
        rest <= quo;
      end
      if (cmd.clr_ok) begin
        ok <= 1'b0;
      end
      if (cmd.cnt_inc && count != sfpc_pkg::COUNT_MAX) begin
        count <= count + 1'b1;
      end
      if (cmd.next_div) begin
        div <= div + 1'b1;
        sq  <= sq + SQW'({div, 1'b1});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      prime_count <= fin_count;
      squarefree  <= ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.loop_go  = ok && (sq <= SQW'(rest));
  assign sts.div_done = div_done;
  assign sts.rem_zero = rem_zero;
  assign sts.out_busy = out_valid && !out_ready;

  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> ok == (rest > WIDTH'(1)))
    else $error("ok flag does not follow loaded number");

  a_nsf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !squarefree |-> prime_count == '0)
    else $error("nonzero count on non-squarefree result");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

// File: rtl/sfpc_ctrl.sv
// controller state machine for trial division
module sfpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfpc_pkg::status_t sts,
  output sfpc_pkg::cmd_t    cmd
);
  sfpc_pkg::state_t state;
  sfpc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfpc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      sfpc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sfpc_pkg::S_CHECK;
        end
      end
      sfpc_pkg::S_CHECK: begin
        if (sts.loop_go) begin
          cmd.div_start = 1'b1;
          state_next    = sfpc_pkg::S_DIV1;
        end else begin
          state_next = sfpc_pkg::S_FINISH;
        end
      end
      sfpc_pkg::S_DIV1: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.take_quot = 1'b1;
            state_next    = sfpc_pkg::S_START2;
          end else begin
            cmd.next_div = 1'b1;
            state_next   = sfpc_pkg::S_CHECK;
          end
        end
      end
      sfpc_pkg::S_START2: begin
        cmd.div_start = 1'b1;
        state_next    = sfpc_pkg::S_DIV2;
      end
      sfpc_pkg::S_DIV2: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.clr_ok = 1'b1;
          end else begin
            cmd.cnt_inc  = 1'b1;
            cmd.next_div = 1'b1;
          end
          state_next = sfpc_pkg::S_CHECK;
        end
      end
      sfpc_pkg::S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = sfpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sfpc_pkg::S_IDLE;
      end
    endcase
  end

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == sfpc_pkg::S_DIV1 || state == sfpc_pkg::S_DIV2))
    else $error("divider done outside a wait state");

  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == sfpc_pkg::S_DIV1 || state == sfpc_pkg::S_DIV2))
    else $error("divider started without waiting");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    state == sfpc_pkg::S_FINISH && !sts.out_busy |=> state == sfpc_pkg::S_IDLE)
    else $error("finish did not return to idle");

endmodule

// File: rtl/squarefree_prime_factor_counter_top.sv
// top level of the squarefree prime factor counter
//
//   channel  dir  payload                       beat
//   num_ch   in   number[WIDTH-1:0]             one number to classify
//   res_ch   out  prime_count[2:0], squarefree  one result per number
//
// each trial divisor costs one pass of the one-bit-per-cycle divider,
// and a second pass when it divides
// reset clears the state machine, divider control and result valid; no sweep
// a number is taken in idle even while the previous result beat waits
// a finished result waits in its state until the result register is free
module squarefree_prime_factor_counter_top #(
  parameter int WIDTH = sfpc_pkg::WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sfpc_in_if.sink    num_ch,
  sfpc_out_if.source res_ch
);
  sfpc_pkg::cmd_t    cmd;
  sfpc_pkg::status_t sts;

  sfpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (num_ch.valid),
    .in_ready (num_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfpc_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .number      (num_ch.number),
    .cmd         (cmd),
    .sts         (sts),
    .prime_count (res_ch.prime_count),
    .squarefree  (res_ch.squarefree),
    .out_valid   (res_ch.valid),
    .out_ready   (res_ch.ready)
  );

endmodule

// File: tb/sv/squarefree_prime_factor_counter_top_tb.sv
`timescale 1ns / 1ps
// testbench for the squarefree prime factor counter: directed, random and stall tests
module squarefree_prime_factor_counter_top_tb;

  localparam int WIDTH         = sfpc_pkg::WIDTH_DEF;
  localparam int COUNT_W       = sfpc_pkg::COUNT_W;
  localparam int HOLD_CYCLES   = 12000;
  localparam int IDLE_LIMIT    = 50000;
  localparam int TAIL_CYCLES   = 5000;
  localparam int NUM_MAX       = (1 << WIDTH) - 1;

  typedef struct {
    logic [WIDTH-1:0]   number;
    logic [COUNT_W-1:0] prime_count;
    logic               squarefree;
  } factor_result_t;

  logic clk = 1'b0;
  logic rst;

  sfpc_in_if #(.WIDTH(WIDTH)) num_ch ();
  sfpc_out_if                 res_ch ();

  squarefree_prime_factor_counter_top #(.WIDTH(WIDTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .num_ch (num_ch),
    .res_ch (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  factor_result_t factor_results_q[$];
  int errors        = 0;
  int numbers_sent  = 0;
  int results_seen  = 0;
  int squarefree_n  = 0;
  int max_count     = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int rx_mode       = 0;
  int rx_mode_left  = 0;
  int idle_cycles   = 0;

  int small_primes [0:53] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
    73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151,
    157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229, 233,
    239, 241, 251
  };

  function automatic factor_result_t predict_factors(logic [WIDTH-1:0] n);
    longint unsigned rest;
    longint unsigned divisor;
    int              count;
    bit              ok;
    factor_result_t  r;
    rest  = 64'(n);
    count = 0;
    ok    = rest > 1;
    for (divisor = 2; ok && divisor * divisor <= rest; divisor++) begin
      if (rest % divisor == 0) begin
        rest = rest / divisor;
        if (rest % divisor == 0) ok = 1'b0;
        else count++;
      end
    end
    if (ok && rest > 1) count++;
    if (!ok) count = 0;
    if (count > int'(sfpc_pkg::COUNT_MAX)) count = int'(sfpc_pkg::COUNT_MAX);
    r.number      = n;
    r.prime_count = COUNT_W'(count);
    r.squarefree  = ok;
    return r;
  endfunction

  task automatic send_number(input logic [WIDTH-1:0] n);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        num_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    num_ch.valid  <= 1'b1;
    num_ch.number <= n;
    do @(posedge clk); while (!num_ch.ready);
    factor_results_q.push_back(predict_factors(n));
    numbers_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_drained();
    num_ch.valid <= 1'b0;
    burst_left = 0;
    while (factor_results_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WIDTH-1:0] squarefree_product();
    int n;
    int p;
    int k;
    n = 1;
    k = $urandom_range(1, 6);
    for (int i = 0; i < 4 * k; i++) begin
      p = small_primes[$urandom_range(0, (i < k) ? 9 : 53)];
      if (n % p != 0 && n * p <= NUM_MAX) n = n * p;
    end
    return WIDTH'(n);
  endfunction

  function automatic logic [WIDTH-1:0] repeated_factor_number();
    int p;
    int base;
    p    = small_primes[$urandom_range(0, 20)];
    base = p * p;
    if ($urandom_range(0, 1) == 0 && base * p <= NUM_MAX) base = base * p;
    return WIDTH'(base * $urandom_range(1, NUM_MAX / base));
  endfunction

  function automatic logic [WIDTH-1:0] large_prime();
    logic [WIDTH-1:0] n;
    factor_result_t   r;
    do begin
      n = WIDTH'($urandom_range(NUM_MAX / 2, NUM_MAX));
      r = predict_factors(n);
    end while (!(r.squarefree && r.prime_count == 1));
    return n;
  endfunction

  function automatic logic [WIDTH-1:0] random_number();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) return squarefree_product();
    else if (kind < 60) return repeated_factor_number();
    else if (kind < 85) return WIDTH'($urandom_range(0, NUM_MAX));
    else if (kind < 95) return WIDTH'($urandom_range(0, 400));
    else return large_prime();
  endfunction

  task automatic test_directed();
    int values [$] = '{0, 1, 2, 3, 4, 6, 9, 12, 18, 50, 30030, 15015, 46189,
                       65535, 65534, 65521, 65025, 63001, 32768, 32767, 64507,
                       65498, 21845};
    foreach (values[i]) send_number(WIDTH'(values[i]));
  endtask

  task automatic test_random();
    repeat (110) send_number(random_number());
  endtask

  task automatic test_backpressure();
    hold_requests++;
    burst_left = 100;
    repeat (8) send_number(random_number());
    burst_left = 0;
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (6) send_number(random_number());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served  = hold_requests;
      hold_left    = HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(5, 60);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        default: res_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    factor_result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (factor_results_q.size() == 0) begin
        $error("unexpected result beat: prime_count %0d squarefree %0d",
               res_ch.prime_count, res_ch.squarefree);
        errors++;
      end else begin
        exp_r = factor_results_q.pop_front();
        results_seen++;
        if (res_ch.prime_count !== exp_r.prime_count) begin
          $error("prime_count (number %0d): expected %0d, actual %0d",
                 exp_r.number, exp_r.prime_count, res_ch.prime_count);
          errors++;
        end
        if (res_ch.squarefree !== exp_r.squarefree) begin
          $error("squarefree (number %0d): expected %0d, actual %0d",
                 exp_r.number, exp_r.squarefree, res_ch.squarefree);
          errors++;
        end
        if (exp_r.squarefree) squarefree_n++;
        if (int'(exp_r.prime_count) > max_count) max_count = int'(exp_r.prime_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (num_ch.valid && num_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("** squarefree_prime_factor_counter_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    res_ch.ready  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d numbers with %0d results checked, %0d squarefree",
             numbers_sent, results_seen, squarefree_n);
    $display("largest prime count seen %0d, long result stall and full drain included",
             max_count);
    if (errors == 0) begin
      $display("** squarefree_prime_factor_counter_top: PASSED **");
    end else begin
      $display("** squarefree_prime_factor_counter_top: FAILED **");
    end
    $finish;
  end

endmodule
